FILE: sv/aatu_pkg.sv
// aatu_pkg: shared codes and sizes of the affine box transform unit
// no dependencies
package aatu_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_BOX  = 1'b1
    } t_op;

    localparam int unsigned NUM_ROWS   = 4;
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned ROW_BITS   = 2;
    localparam int unsigned ENTRY_COLS = 6;

endpackage

FILE: sv/aatu_if.sv
// aatu_in_if, aatu_out_if: valid/ready channels of the box transform unit
// no dependencies
interface aatu_in_if #(
    parameter int unsigned W = 32
);
    logic                valid;
    logic                ready;
    logic                operation;
    logic [1:0]          row_index;
    logic signed [W-1:0] m_c0;
    logic signed [W-1:0] m_c1;
    logic signed [W-1:0] m_c2;
    logic signed [W-1:0] m_c3;
    logic signed [W-1:0] min_x;
    logic signed [W-1:0] min_y;
    logic signed [W-1:0] min_z;
    logic signed [W-1:0] max_x;
    logic signed [W-1:0] max_y;
    logic signed [W-1:0] max_z;

    modport source (
        output valid, operation, row_index, m_c0, m_c1, m_c2, m_c3,
               min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );
    modport sink (
        input  valid, operation, row_index, m_c0, m_c1, m_c2, m_c3,
               min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

interface aatu_out_if #(
    parameter int unsigned W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_min_x;
    logic signed [W-1:0] out_min_y;
    logic signed [W-1:0] out_min_z;
    logic signed [W-1:0] out_max_x;
    logic signed [W-1:0] out_max_y;
    logic signed [W-1:0] out_max_z;
    logic                saturated;

    modport source (
        output valid, out_min_x, out_min_y, out_min_z,
               out_max_x, out_max_y, out_max_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_min_x, out_min_y, out_min_z,
               out_max_x, out_max_y, out_max_z, saturated,
        output ready
    );
endinterface

FILE: sv/aatu_front.sv
// aatu_front: accepts input transfers, classifies them and packs queue entries
// depends on aatu_pkg, aatu_in_if
module aatu_front #(
    parameter int unsigned W  = 32,
    parameter int unsigned EW = 3 + 6 * W
) (
    aatu_in_if.sink     i_in,
    output logic        o_push,
    output logic [EW-1:0] o_entry,
    input  logic        i_full
);
    logic          is_box;
    logic [1:0]    row;
    logic [6*W-1:0] data;

    always_comb begin
        is_box = (i_in.operation == aatu_pkg::OP_BOX);
        if (is_box) begin
            row  = '0;
            data = {i_in.max_z, i_in.max_y, i_in.max_x,
                    i_in.min_z, i_in.min_y, i_in.min_x};
        end else begin
            row  = i_in.row_index;
            data = {{(2*W){1'b0}}, i_in.m_c3, i_in.m_c2, i_in.m_c1, i_in.m_c0};
        end
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_entry    = {is_box, row, data};

endmodule

FILE: sv/aatu_queue.sv
// aatu_queue: short first-in first-out queue between front and back
// no dependencies
module aatu_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign do_push = i_push && (r_cnt != FULLC);
    assign o_full  = (r_cnt == FULLC);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: sv/aatu_back.sv
// aatu_back: matrix store and box transform pipeline (multiply, select, sum, clamp)
// depends on aatu_pkg, aatu_out_if
module aatu_back #(
    parameter int unsigned W  = 32,
    parameter int unsigned F  = 16,
    parameter int unsigned EW = 3 + 6 * W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [EW-1:0] i_entry,
    output logic          o_pop,
    aatu_out_if.source    o_out
);
    localparam int unsigned PWID = 2 * W;
    localparam int unsigned SW   = 2 * W + 2;
    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;
    localparam logic signed [W-1:0]  ONE  = W'(1) << F;

    logic signed [W-1:0]    r_mat [4][4];
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic signed [PWID-1:0] r_plo [3][3];
    logic signed [PWID-1:0] r_phi [3][3];
    logic signed [W-1:0]    r_w1 [3];
    logic signed [PWID-1:0] r_mn [3][3];
    logic signed [PWID-1:0] r_mx [3][3];
    logic signed [W-1:0]    r_w2 [3];
    logic signed [SW-1:0]   r_smn [3];
    logic signed [SW-1:0]   r_smx [3];
    logic signed [W-1:0]    r_omn [3];
    logic signed [W-1:0]    r_omx [3];
    logic                   r_sat;

    logic                   en, is_box, is_load;
    logic [1:0]             row;
    logic signed [W-1:0]    lo [3];
    logic signed [W-1:0]    hi [3];
    logic signed [W-1:0]    col [4];
    logic signed [PWID-1:0] n_plo [3][3];
    logic signed [PWID-1:0] n_phi [3][3];
    logic signed [SW-1:0]   n_smn [3];
    logic signed [SW-1:0]   n_smx [3];
    logic signed [SW-1:0]   wterm [3];
    logic signed [SW-1:0]   tmn [3];
    logic signed [SW-1:0]   tmx [3];
    logic signed [W-1:0]    n_omn [3];
    logic signed [W-1:0]    n_omx [3];
    logic                   n_sat;

    assign en      = !r_v4 || o_out.ready;
    assign o_pop   = en && i_valid;
    assign is_box  = (i_entry[EW-1] == aatu_pkg::OP_BOX);
    assign is_load = o_pop && !is_box;
    assign row     = i_entry[EW-2:EW-3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo[a] = i_entry[a*W +: W];
            hi[a] = i_entry[(a+3)*W +: W];
        end
        for (int c = 0; c < 4; c++) begin
            col[c] = i_entry[c*W +: W];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_plo[r][c] = PWID'(lo[r]) * PWID'(r_mat[r][c]);
                n_phi[r][c] = PWID'(hi[r]) * PWID'(r_mat[r][c]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            wterm[c] = SW'(r_w2[c]) <<< F;
            n_smn[c] = SW'(r_mn[0][c]) + SW'(r_mn[1][c]) + SW'(r_mn[2][c]) + wterm[c];
            n_smx[c] = SW'(r_mx[0][c]) + SW'(r_mx[1][c]) + SW'(r_mx[2][c]) + wterm[c];
        end
        n_sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            tmn[c] = r_smn[c] >>> F;
            tmx[c] = r_smx[c] >>> F;
            if (tmn[c] > MAXV) begin
                n_omn[c] = W'(MAXV);
                n_sat    = 1'b1;
            end else if (tmn[c] < MINV) begin
                n_omn[c] = W'(MINV);
                n_sat    = 1'b1;
            end else begin
                n_omn[c] = W'(tmn[c]);
            end
            if (tmx[c] > MAXV) begin
                n_omx[c] = W'(MAXV);
                n_sat    = 1'b1;
            end else if (tmx[c] < MINV) begin
                n_omx[c] = W'(MINV);
                n_sat    = 1'b1;
            end else begin
                n_omx[c] = W'(tmx[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else begin
            if (en) begin
                r_v1 <= o_pop && is_box;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
            if (is_load) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[row][c] <= col[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_plo[r][c] <= n_plo[r][c];
                    r_phi[r][c] <= n_phi[r][c];
                    if (r_plo[r][c] < r_phi[r][c]) begin
                        r_mn[r][c] <= r_plo[r][c];
                        r_mx[r][c] <= r_phi[r][c];
                    end else begin
                        r_mn[r][c] <= r_phi[r][c];
                        r_mx[r][c] <= r_plo[r][c];
                    end
                end
            end
            for (int c = 0; c < 3; c++) begin
                r_w1[c]  <= r_mat[3][c];
                r_w2[c]  <= r_w1[c];
                r_smn[c] <= n_smn[c];
                r_smx[c] <= n_smx[c];
                r_omn[c] <= n_omn[c];
                r_omx[c] <= n_omx[c];
            end
            r_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_v4;
    assign o_out.out_min_x = r_omn[0];
    assign o_out.out_min_y = r_omn[1];
    assign o_out.out_min_z = r_omn[2];
    assign o_out.out_max_x = r_omx[0];
    assign o_out.out_max_y = r_omx[1];
    assign o_out.out_max_z = r_omx[2];
    assign o_out.saturated = r_sat;

endmodule

FILE: sv/aabb_affine_transform_unit.sv
// channel  | direction | carries
// i_in     | sink      | matrix row load or box min/max corners
// o_out    | source    | transformed box min/max corners and saturation flag
// a box result passes the four-stage multiply/select/sum/clamp pipeline after it leaves
// the queue; one item per cycle sustained while the output is not stalled
// row loads are written into the matrix store when they leave the queue and produce no transfer
// synchronous active-low reset sets the matrix to identity and empties the queue
// a stalled output holds the pipeline; the queue keeps taking items until full
module aabb_affine_transform_unit #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aatu_in_if.sink     i_in,
    aatu_out_if.source  o_out
);
    localparam int unsigned EW = 3 + 6 * COORD_WIDTH;

    logic          push, full, pop, qvalid;
    logic [EW-1:0] push_entry, head_entry;

    aatu_front #(.W(COORD_WIDTH), .EW(EW)) u_front (
        .i_in    (i_in),
        .o_push  (push),
        .o_entry (push_entry),
        .i_full  (full)
    );

    aatu_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (head_entry)
    );

    aatu_back #(.W(COORD_WIDTH), .F(FRAC_BITS), .EW(EW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qvalid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
